### src/sgp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sgp_pkg;

    localparam int RESULT_LIMIT     = 16;
    localparam int DEF_MAX_CHANNELS = 16;
    localparam int CC_W             = 5;
    localparam logic [CC_W-1:0] CC_RESET = 5'd8;

    // sine polynomial coefficients, Q15
    localparam int SIN_A = 51472;
    localparam int SIN_B = 21023;
    localparam int SIN_C = 2320;

    // divider widths: remainder, quotient, step count
    localparam int RW = 36;
    localparam int QW = 32;
    localparam int SW = 6;

    localparam logic [SW-1:0] STEPS_PHI  = 6'd17;
    localparam logic [SW-1:0] STEPS_WGT  = 6'd32;
    localparam logic [SW-1:0] STEPS_GAIN = 6'd17;

    typedef struct packed {
        logic [15:0]        time_stamp;
        logic signed [15:0] angle;
        logic [15:0]        radius;
    } in_t;

    typedef struct packed {
        logic [3:0]  channel;
        logic [15:0] gain;
        logic [15:0] stamp_out;
        logic        last;
    } out_t;

    typedef struct packed {
        logic          start;
        logic [SW-1:0] steps;
        logic [RW-1:0] rem;
        logic [QW-1:0] bits;
        logic [RW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic          done;
        logic [QW-1:0] quot;
    } div_rsp_t;

endpackage

`default_nettype wire

### src/sgp_div.sv
`timescale 1ns / 1ps
`default_nettype none

module sgp_div
    import sgp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic [RW-1:0] rem_reg, rem_next;
    logic [RW-1:0] div_reg;
    logic [QW-1:0] bits_reg;
    logic [QW-1:0] quo_reg;
    logic [SW-1:0] cnt_reg;
    logic          run_reg;
    logic          done_reg;
    logic [RW:0]   trial;
    logic          ge;

    // one quotient bit per cycle, restoring
    assign trial = {rem_reg, bits_reg[QW-1]};
    assign ge    = trial >= {1'b0, div_reg};

    always_comb
    begin
        if (ge)
        begin
            rem_next = RW'(trial - {1'b0, div_reg});
        end
        else
        begin
            rem_next = trial[RW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == SW'(1));
            if (req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= req.steps;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - SW'(1);
                if (cnt_reg == SW'(1))
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= req.rem;
            bits_reg <= req.bits;
            div_reg  <= req.divisor;
            quo_reg  <= '0;
        end
        else if (run_reg)
        begin
            rem_reg  <= rem_next;
            bits_reg <= {bits_reg[QW-2:0], 1'b0};
            quo_reg  <= {quo_reg[QW-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;

endmodule

`default_nettype wire

### src/sgp_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module sgp_mul
(
    input  wire logic               clk,
    input  wire logic signed [17:0] a,
    input  wire logic signed [17:0] b,
    output logic signed [35:0]      p
);

    logic signed [35:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

`default_nettype wire

### src/speaker_gain_from_polar_location.sv
`timescale 1ns / 1ps
`default_nettype none
// one input beat computes the weights speaker by speaker (17-step phase divide,
// six passes through the shared multiplier, 32-step weight divide), then the gains
// speaker by speaker with 17-step gain divides; while the output register stays
// stalled the sequencer waits before loading the next gain
// the next input beat is taken once the last gain is loaded into the output register
// rst_n clears the sequencer, the output valid and sets channel_count to 8; no clearing pass

module speaker_gain_from_polar_location
    import sgp_pkg::*;
#(
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
)(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire in_t             in_data,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output out_t                 out_data,
    input  wire logic            cfg_write,
    input  wire logic [CC_W-1:0] cfg_data
);

    localparam int LIMIT = (MAX_CHANNELS < RESULT_LIMIT) ? MAX_CHANNELS : RESULT_LIMIT;
    localparam int CNT_W = $clog2(LIMIT + 1);
    localparam int IDX_W = (LIMIT > 1) ? $clog2(LIMIT) : 1;

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_PHI   = 15'b000000000000010,
        S_PHI_W = 15'b000000000000100,
        S_MUU   = 15'b000000000001000,
        S_MC    = 15'b000000000010000,
        S_MB    = 15'b000000000100000,
        S_MA    = 15'b000000001000000,
        S_MRR   = 15'b000000010000000,
        S_MRC   = 15'b000000100000000,
        S_DSQ   = 15'b000001000000000,
        S_WDV   = 15'b000010000000000,
        S_WDV_W = 15'b000100000000000,
        S_GDV   = 15'b001000000000000,
        S_GDV_W = 15'b010000000000000,
        S_GOUT  = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [CC_W-1:0]  cc_reg;
    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] i_reg;
    logic [15:0]      stamp_reg;
    logic [15:0]      ang_reg;
    logic [15:0]      r_reg;
    logic [15:0]      u_reg;
    logic             neg_reg;
    logic [16:0]      u2_reg;
    logic signed [17:0] c_reg;
    logic [32:0]      rr_reg;
    logic [RW-1:0]    den_reg;
    logic [RW-1:0]    sum_reg;
    logic [QW-1:0]    w_mem [LIMIT];
    logic             out_valid_reg;
    out_t             out_data_reg;

    logic [CNT_W-1:0]   n_eff;
    logic               is_last;
    logic [CNT_W:0]     i_inc;
    logic               out_load;
    logic [15:0]        diff;
    logic [15:0]        s_ang;
    logic [15:0]        u_raw;
    logic [16:0]        t_p;
    logic [16:0]        t_clamp;
    logic signed [17:0] mul_a, mul_b;
    logic signed [35:0] mul_p;
    logic signed [36:0] d2;
    logic [47:0]        gain_dvd;
    logic [QW-1:0]      w_rd;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    sgp_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    sgp_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        if (cc_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (cc_reg > CC_W'(LIMIT))
        begin
            n_eff = CNT_W'(LIMIT);
        end
        else
        begin
            n_eff = CNT_W'(cc_reg);
        end
    end

    assign i_inc    = {1'b0, i_reg} + (CNT_W + 1)'(1);
    assign is_last  = i_inc == {1'b0, n_reg};
    assign in_stall = state_reg != S_IDLE;
    assign out_load = (state_reg == S_GOUT) && (!out_valid_reg || !out_stall);
    assign w_rd     = w_mem[i_reg[IDX_W-1:0]];

    // quarter-wave fold of the speaker-relative angle, cosine as shifted sine
    assign diff  = ang_reg - div_rsp.quot[15:0];
    assign s_ang = diff + 16'd16384;
    assign u_raw = {1'b0, s_ang[13:0], 1'b0};

    assign t_p     = mul_p[31:15];
    assign t_clamp = (t_p > 17'd32768) ? 17'd32768 : t_p;

    assign d2 = $signed({4'b0, rr_reg}) + (37'sd1 <<< 30) - $signed({mul_p, 1'b0});
    assign gain_dvd = {w_rd, 16'b0} + {13'b0, sum_reg[RW-1:1]};

    always_comb
    begin
        mul_a = $signed({2'b0, u_reg});
        mul_b = $signed({2'b0, u_reg});
        unique case (state_reg)
            S_MC:
            begin
                mul_a = $signed(18'(SIN_C));
                mul_b = $signed({1'b0, t_p});
            end
            S_MB:
            begin
                mul_a = $signed(18'(SIN_B)) - $signed({1'b0, t_p});
                mul_b = $signed({1'b0, u2_reg});
            end
            S_MA:
            begin
                mul_a = $signed(18'(SIN_A)) - $signed({1'b0, t_p});
                mul_b = $signed({2'b0, u_reg});
            end
            S_MRR:
            begin
                mul_a = $signed({2'b0, r_reg});
                mul_b = $signed({2'b0, r_reg});
            end
            S_MRC:
            begin
                mul_a = $signed({2'b0, r_reg});
                mul_b = c_reg;
            end
            default:
            begin
                mul_a = $signed({2'b0, u_reg});
                mul_b = $signed({2'b0, u_reg});
            end
        endcase
    end

    always_comb
    begin
        div_req.start   = 1'b0;
        div_req.steps   = STEPS_PHI;
        div_req.rem     = RW'(i_reg >> 1);
        div_req.bits    = {i_reg[0], 31'b0};
        div_req.divisor = RW'(n_reg);
        unique case (state_reg)
            S_PHI:
            begin
                div_req.start = 1'b1;
            end
            S_WDV:
            begin
                // 2^60 / den: 2^28 preloaded as the remainder, 32 zero bits shifted in
                div_req.start   = 1'b1;
                div_req.steps   = STEPS_WGT;
                div_req.rem     = RW'(1) << 28;
                div_req.bits    = '0;
                div_req.divisor = den_reg;
            end
            S_GDV:
            begin
                div_req.start   = 1'b1;
                div_req.steps   = STEPS_GAIN;
                div_req.rem     = RW'(gain_dvd[47:17]);
                div_req.bits    = {gain_dvd[16:0], 15'b0};
                div_req.divisor = sum_reg;
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_PHI;
            S_PHI:   state_next = S_PHI_W;
            S_PHI_W: if (div_rsp.done) state_next = S_MUU;
            S_MUU:   state_next = S_MC;
            S_MC:    state_next = S_MB;
            S_MB:    state_next = S_MA;
            S_MA:    state_next = S_MRR;
            S_MRR:   state_next = S_MRC;
            S_MRC:   state_next = S_DSQ;
            S_DSQ:   state_next = S_WDV;
            S_WDV:   state_next = S_WDV_W;
            S_WDV_W:
            begin
                if (div_rsp.done)
                begin
                    state_next = is_last ? S_GDV : S_PHI;
                end
            end
            S_GDV:   state_next = S_GDV_W;
            S_GDV_W: if (div_rsp.done) state_next = S_GOUT;
            S_GOUT:
            begin
                if (out_load)
                begin
                    state_next = is_last ? S_IDLE : S_GDV;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cc_reg        <= CC_RESET;
            i_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                cc_reg <= cfg_data;
            end
            if (state_reg == S_IDLE)
            begin
                i_reg <= '0;
            end
            else if ((state_reg == S_WDV_W) && div_rsp.done)
            begin
                i_reg <= is_last ? '0 : i_inc[CNT_W-1:0];
            end
            else if (out_load && !is_last)
            begin
                i_reg <= i_inc[CNT_W-1:0];
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                n_reg     <= n_eff;
                stamp_reg <= in_data.time_stamp;
                ang_reg   <= in_data.angle;
                r_reg     <= in_data.radius;
                sum_reg   <= '0;
            end
            S_PHI_W:
            begin
                u_reg   <= s_ang[14] ? (16'd32768 - u_raw) : u_raw;
                neg_reg <= s_ang[15];
            end
            S_MC:
            begin
                u2_reg <= t_p;
            end
            S_MRR:
            begin
                c_reg <= neg_reg ? -$signed({1'b0, t_clamp}) : $signed({1'b0, t_clamp});
            end
            S_MRC:
            begin
                rr_reg <= mul_p[32:0];
            end
            S_DSQ:
            begin
                den_reg <= (d2[36] ? RW'(0) : d2[RW-1:0]) + (RW'(1) << 29);
            end
            S_WDV_W:
            begin
                if (div_rsp.done)
                begin
                    w_mem[i_reg[IDX_W-1:0]] <= div_rsp.quot;
                    sum_reg <= sum_reg + RW'(div_rsp.quot);
                end
            end
            S_GOUT:
            begin
                if (out_load)
                begin
                    out_data_reg.channel   <= 4'(i_reg);
                    out_data_reg.gain      <= (div_rsp.quot[QW-1:16] != '0) ? 16'hFFFF
                                              : div_rsp.quot[15:0];
                    out_data_reg.stamp_out <= stamp_reg;
                    out_data_reg.last      <= is_last;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // divider results only land while the sequencer waits for them
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_PHI_W || state_reg == S_WDV_W
                          || state_reg == S_GDV_W))
        else $error("divider done outside a wait state");

    a_sum_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GDV) |-> (sum_reg != '0))
        else $error("gain divide started with zero weight sum");

    a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ({1'b0, out_data_reg.channel} < 5'(n_reg)))
        else $error("output channel beyond speaker count");

    a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && is_last) |=> (state_reg == S_IDLE))
        else $error("final speaker beat did not end the item");

endmodule

`default_nettype wire
